// ----- rtl/core/websocket_frame_receiver_top_macros.svh -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver assertion macros
// Property helpers used by the checker file of the receiver.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_RECEIVER_TOP_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_TOP_MACROS_SVH

// same-cycle implication
`define WSFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wsfr check failed");

// next-cycle implication
`define WSFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wsfr check failed");

`endif

// ----- rtl/core/wsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Shared constants, codes and the queue entry type.
// ----------------------------------------------------------------------------
package wsfr_pkg;

   localparam int FRAME_LENGTH_BITS_DEF = 64;
   localparam int QUEUE_DEPTH           = 4;
   localparam int CSR_INDEX_W           = 2;

   localparam logic [31:0] MAX_MESSAGE_RESET = 32'(1024 * 1024 * 32);

   localparam logic [CSR_INDEX_W-1:0] REG_MAX_MESSAGE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ACCEPT_UNMASKED = 2'd1;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_END     = 2'd1;
   localparam logic [1:0] KIND_PONG    = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic CAUSE_NO_MASK  = 1'b0;
   localparam logic CAUSE_TOO_LONG = 1'b1;

   localparam logic [3:0] OP_CONT   = 4'd0;
   localparam logic [3:0] OP_TEXT   = 4'd1;
   localparam logic [3:0] OP_BINARY = 4'd2;
   localparam logic [3:0] OP_PING   = 4'd9;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] raw_byte;
      logic [7:0] key_byte;
      logic [3:0] opcode;
      logic       msg_end;
      logic       cause;
   } entry_type;

endpackage

// ----- rtl/core/websocket_frame_receiver_top.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// A result beat is registered in the queue, then in the output register.
// Throughput: one byte per cycle; the parser updates its frame state on each
// accepted byte and only stalls when the four-beat queue is full.
// Reset: synchronous; parser returns to the first header byte, queue empties,
// limits return to 32 MiB and mask required. No clearing pass.
// ----------------------------------------------------------------------------
module websocket_frame_receiver_top #(
   parameter int FRAME_LENGTH_BITS = wsfr_pkg::FRAME_LENGTH_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_stream_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_result_kind,
   output logic [7:0]                       rsp_payload_byte,
   output logic [3:0]                       rsp_message_opcode,
   output logic                             rsp_message_end,
   output logic                             rsp_error_cause,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wsfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wdata
);
   import wsfr_pkg::*;

   logic [31:0] max_msg_ff;
   logic        acc_unmasked_ff;
   logic        push;
   entry_type   push_entry;
   logic        pop;
   logic        full;
   logic        head_valid;
   entry_type   head_entry;

   assign csr_ready = 1'b1;
   assign req_stall = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_msg_ff      <= MAX_MESSAGE_RESET;
         acc_unmasked_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_MAX_MESSAGE) begin
            max_msg_ff <= csr_wdata;
         end else if (csr_index == REG_ACCEPT_UNMASKED) begin
            acc_unmasked_ff <= csr_wdata[0];
         end
      end
   end

   wsfr_parser #(
      .FRAME_LENGTH_BITS(FRAME_LENGTH_BITS)
   ) u_parser (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stream_byte   (req_stream_byte),
      .queue_full        (full),
      .max_message_bytes (max_msg_ff),
      .accept_unmasked   (acc_unmasked_ff),
      .push              (push),
      .push_entry        (push_entry)
   );

   wsfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   wsfr_output u_output (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_entry         (head_entry),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_message_opcode (rsp_message_opcode),
      .rsp_message_end    (rsp_message_end),
      .rsp_error_cause    (rsp_error_cause)
   );

endmodule

// ----- rtl/core/wsfr_parser.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver parser
// Front end: walks the frame header, tracks message size and opcode, and
// pushes one classified beat per byte that causes a result.
// ----------------------------------------------------------------------------
module wsfr_parser #(
   parameter int FRAME_LENGTH_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [7:0]           req_stream_byte,
   input  logic                 queue_full,
   input  logic [31:0]          max_message_bytes,
   input  logic                 accept_unmasked,
   output logic                 push,
   output wsfr_pkg::entry_type  push_entry
);
   import wsfr_pkg::*;

   localparam int LW    = FRAME_LENGTH_BITS;
   localparam int CMP_W = (LW > 32) ? LW : 32;

   typedef enum logic [2:0] {
      PH_HEAD1,
      PH_HEAD2,
      PH_EXTLEN,
      PH_MASK,
      PH_PAYLOAD
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [4:0]  flags_ff, flags_in;
   logic        masked_ff, masked_in;
   logic [LW-1:0] shift_ff, shift_in;
   logic [3:0]  left_ff, left_in;
   logic [31:0] key_ff, key_in;
   logic [LW-1:0] pl_ff, pl_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] msg_ff, msg_in;
   logic [3:0]  cur_op_ff, cur_op_in;
   logic        closed_ff, closed_in;

   logic          accept;
   logic          do_len;
   logic          do_begin;
   logic [LW-1:0] len_val;
   logic [LW-1:0] shift_next;
   logic [LW-1:0] begin_pl;
   logic [CMP_W-1:0] len_cmp;
   logic [32:0]   sum_cmp;
   logic          too_long;
   logic [3:0]    op;
   logic [6:0]    len7;

   assign accept = req_valid && !queue_full;
   assign op     = flags_ff[3:0];
   assign len7   = req_stream_byte[6:0];

   always_comb begin
      phase_in   = phase_ff;
      flags_in   = flags_ff;
      masked_in  = masked_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      key_in     = key_ff;
      pl_in      = pl_ff;
      idx_in     = idx_ff;
      msg_in     = msg_ff;
      cur_op_in  = cur_op_ff;
      closed_in  = closed_ff;
      push       = 1'b0;
      push_entry = '{kind: KIND_PAYLOAD, raw_byte: 8'd0, key_byte: 8'd0,
                     opcode: cur_op_ff, msg_end: 1'b0, cause: 1'b0};
      do_len     = 1'b0;
      do_begin   = 1'b0;
      len_val    = '0;
      shift_next = '1;
      if (shift_ff[LW-1 -: 8] == 8'd0) begin
         shift_next = {shift_ff[LW-9:0], req_stream_byte};
      end
      if (accept && !closed_ff) begin
         case (phase_ff)
            PH_HEAD1: begin
               flags_in = {req_stream_byte[7], req_stream_byte[3:0]};
               phase_in = PH_HEAD2;
            end
            PH_HEAD2: begin
               masked_in = req_stream_byte[7];
               phase_in  = PH_HEAD1;
               if (op == OP_PING) begin
                  push            = 1'b1;
                  push_entry.kind = KIND_PONG;
               end else if (op == OP_CONT || op == OP_TEXT || op == OP_BINARY) begin
                  if (!accept_unmasked && !req_stream_byte[7]) begin
                     closed_in        = 1'b1;
                     push             = 1'b1;
                     push_entry.kind  = KIND_ERROR;
                     push_entry.cause = CAUSE_NO_MASK;
                  end else begin
                     key_in   = '0;
                     idx_in   = '0;
                     shift_in = '0;
                     if (len7 == LEN_EXT16) begin
                        left_in  = 4'd2;
                        phase_in = PH_EXTLEN;
                     end else if (len7 == LEN_EXT64) begin
                        left_in  = 4'd8;
                        phase_in = PH_EXTLEN;
                     end else begin
                        len_val = LW'(len7);
                        do_len  = 1'b1;
                     end
                  end
               end
            end
            PH_EXTLEN: begin
               shift_in = shift_next;
               left_in  = left_ff - 4'd1;
               if (left_ff == 4'd1) begin
                  len_val = shift_next;
                  do_len  = 1'b1;
               end
            end
            PH_MASK: begin
               key_in  = {key_ff[23:0], req_stream_byte};
               left_in = left_ff - 4'd1;
               if (left_ff == 4'd1) begin
                  do_begin = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               push                = 1'b1;
               push_entry.raw_byte = req_stream_byte;
               push_entry.key_byte = key_ff[(2'd3 - idx_ff) * 8 +: 8];
               push_entry.msg_end  = (pl_ff == LW'(1)) && flags_ff[4];
               idx_in = idx_ff + 2'd1;
               pl_in  = pl_ff - LW'(1);
               if (pl_ff == LW'(1)) begin
                  phase_in = PH_HEAD1;
                  if (flags_ff[4]) begin
                     msg_in    = '0;
                     cur_op_in = OP_CONT;
                  end
               end
            end
            default: begin
               phase_in = PH_HEAD1;
            end
         endcase
      end

      len_cmp  = CMP_W'(len_val);
      sum_cmp  = {1'b0, msg_ff} + {1'b0, len_cmp[31:0]};
      too_long = (len_cmp >= CMP_W'(max_message_bytes)) ||
                 (sum_cmp >= {1'b0, max_message_bytes});
      if (do_len) begin
         if (too_long) begin
            closed_in        = 1'b1;
            push             = 1'b1;
            push_entry.kind  = KIND_ERROR;
            push_entry.cause = CAUSE_TOO_LONG;
         end else begin
            msg_in = sum_cmp[31:0];
            pl_in  = len_val;
            if (cur_op_ff == OP_CONT && op != OP_CONT) begin
               cur_op_in = op;
            end
            if (masked_in) begin
               left_in  = 4'd4;
               phase_in = PH_MASK;
            end else begin
               do_begin = 1'b1;
            end
         end
      end

      begin_pl = do_len ? len_val : pl_ff;
      if (do_begin) begin
         if (begin_pl == '0) begin
            phase_in = PH_HEAD1;
            if (flags_ff[4]) begin
               push              = 1'b1;
               push_entry.kind   = KIND_END;
               push_entry.msg_end = 1'b1;
               push_entry.opcode = cur_op_in;
               msg_in            = '0;
               cur_op_in         = OP_CONT;
            end
         end else begin
            phase_in = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEAD1;
         flags_ff  <= '0;
         masked_ff <= 1'b0;
         shift_ff  <= '0;
         left_ff   <= '0;
         key_ff    <= '0;
         pl_ff     <= '0;
         idx_ff    <= '0;
         msg_ff    <= '0;
         cur_op_ff <= OP_CONT;
         closed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         flags_ff  <= flags_in;
         masked_ff <= masked_in;
         shift_ff  <= shift_in;
         left_ff   <= left_in;
         key_ff    <= key_in;
         pl_ff     <= pl_in;
         idx_ff    <= idx_in;
         msg_ff    <= msg_in;
         cur_op_ff <= cur_op_in;
         closed_ff <= closed_in;
      end
   end

endmodule

// ----- rtl/core/wsfr_queue.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver queue
// Short FIFO of classified beats between the parser and the output stage.
// ----------------------------------------------------------------------------
module wsfr_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  wsfr_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 head_valid,
   output wsfr_pkg::entry_type  head_entry
);
   import wsfr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/core/wsfr_output.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver output stage
// Back end: unmasks payload beats and holds the result register.
// ----------------------------------------------------------------------------
module wsfr_output (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  wsfr_pkg::entry_type  head_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_result_kind,
   output logic [7:0]           rsp_payload_byte,
   output logic [3:0]           rsp_message_opcode,
   output logic                 rsp_message_end,
   output logic                 rsp_error_cause
);
   import wsfr_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic [3:0] opcode_ff;
   logic       end_ff;
   logic       cause_ff;

   assign pop      = head_valid && (!valid_ff || !rsp_stall);
   assign valid_in = pop || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (pop) begin
         kind_ff   <= head_entry.kind;
         byte_ff   <= head_entry.raw_byte ^ head_entry.key_byte;
         opcode_ff <= head_entry.opcode;
         end_ff    <= head_entry.msg_end;
         cause_ff  <= head_entry.cause;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_message_opcode = opcode_ff;
   assign rsp_message_end    = end_ff;
   assign rsp_error_cause    = cause_ff;

endmodule

// ----- rtl/core/wsfr_checker.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "websocket_frame_receiver_top_macros.svh"

module wsfr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_result_kind,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_message_end,
   input logic       rsp_error_cause
);
   import wsfr_pkg::*;

   logic       rsp_beat;
   logic       kind_payload;
   logic       kind_pong;
   logic       kind_error;
   logic [9:0] rsp_word;

   assign rsp_beat     = rsp_valid && !rsp_stall;
   assign kind_payload = (rsp_result_kind == KIND_PAYLOAD);
   assign kind_pong    = (rsp_result_kind == KIND_PONG);
   assign kind_error   = (rsp_result_kind == KIND_ERROR);
   assign rsp_word     = {rsp_result_kind, rsp_payload_byte};

   `WSFR_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))
   `WSFR_ASSERT_NEXT(a_closed, clock, reset, rsp_beat && kind_error, !rsp_valid)
   `WSFR_ASSERT_NOW(a_byte_zero, clock, reset, rsp_valid && !kind_payload, rsp_payload_byte == 8'd0)
   `WSFR_ASSERT_NOW(a_cause, clock, reset, rsp_valid && !kind_error, !rsp_error_cause)
   `WSFR_ASSERT_NOW(a_end, clock, reset, rsp_valid && (kind_pong || kind_error), !rsp_message_end)

endmodule

bind websocket_frame_receiver_top wsfr_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_message_end  (rsp_message_end),
   .rsp_error_cause  (rsp_error_cause)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver testbench
// Streams header, extended length, mask key and payload beats into the
// receiver under link and sink idling and under one long sink hold-off.
// A scoreboard class tracks the frame parser state and compares every result
// beat field by field. The run ends with one protocol error that closes the
// receiver, followed by beats that must be dropped.
// ----------------------------------------------------------------------------
module tb_top;
   import wsfr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [3:0] OP_PONG     = 4'd10;
   localparam logic [3:0] OP_RESERVED = 4'd15;

   typedef enum logic [2:0] {
      PH_HEAD1,
      PH_HEAD2,
      PH_EXTLEN,
      PH_MASK,
      PH_PAYLOAD
   } parse_phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [3:0] opcode;
      logic       msg_end;
      logic       cause;
   } ws_result_type;

   class frame_scoreboard_type;
      logic [31:0]     limit_bytes;
      logic            unmasked_ok;
      parse_phase_type phase;
      logic [4:0]      flags;
      logic            masked;
      logic [63:0]     len_acc;
      int              len_left;
      logic [31:0]     key;
      logic [63:0]     pay_left;
      logic [1:0]      key_idx;
      logic [32:0]     msg_bytes;
      logic [3:0]      msg_op;
      logic            closed;
      ws_result_type   awaited[$];
      int              errors;

      function new();
         limit_bytes = MAX_MESSAGE_RESET;
         unmasked_ok = 1'b0;
         phase       = PH_HEAD1;
         flags       = '0;
         masked      = 1'b0;
         len_acc     = '0;
         len_left    = 0;
         key         = '0;
         pay_left    = '0;
         key_idx     = '0;
         msg_bytes   = '0;
         msg_op      = OP_CONT;
         closed      = 1'b0;
         errors      = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
         if (idx == REG_MAX_MESSAGE) begin
            limit_bytes = val;
         end else if (idx == REG_ACCEPT_UNMASKED) begin
            unmasked_ok = val[0];
         end
      endfunction

      function void push(logic [1:0] kind, logic [7:0] data, logic msg_end, logic cause);
         ws_result_type r;
         r.kind    = kind;
         r.data    = data;
         r.opcode  = msg_op;
         r.msg_end = msg_end;
         r.cause   = cause;
         awaited.push_back(r);
      endfunction

      function void finish_message();
         msg_bytes = '0;
         msg_op    = OP_CONT;
      endfunction

      function void start_payload();
         if (pay_left == 0) begin
            phase = PH_HEAD1;
            if (flags[4]) begin
               push(KIND_END, 8'h00, 1'b1, 1'b0);
               finish_message();
            end
         end else begin
            phase = PH_PAYLOAD;
         end
      endfunction

      function void length_done();
         logic [64:0] total;
         logic [64:0] limit;
         total = {32'd0, msg_bytes} + {1'b0, len_acc};
         limit = {33'd0, limit_bytes};
         if ({1'b0, len_acc} >= limit || total >= limit) begin
            closed = 1'b1;
            push(KIND_ERROR, 8'h00, 1'b0, CAUSE_TOO_LONG);
         end else begin
            msg_bytes = total[32:0];
            pay_left  = len_acc;
            if (msg_op == OP_CONT && flags[3:0] != OP_CONT) msg_op = flags[3:0];
            if (masked) begin
               len_left = 4;
               phase    = PH_MASK;
            end else begin
               start_payload();
            end
         end
      endfunction

      function void note_byte(logic [7:0] b);
         logic [63:0] cap;
         logic [7:0]  plain;
         logic        last;
         cap = (FRAME_LENGTH_BITS_DEF >= 64) ? '1 :
               ((64'd1 << FRAME_LENGTH_BITS_DEF) - 64'd1);
         if (closed) return;
         case (phase)
            PH_HEAD1: begin
               flags = {b[7], b[3:0]};
               phase = PH_HEAD2;
            end
            PH_HEAD2: begin
               masked = b[7];
               phase  = PH_HEAD1;
               if (flags[3:0] == OP_PING) begin
                  push(KIND_PONG, 8'h00, 1'b0, 1'b0);
               end else if (flags[3:0] <= OP_BINARY) begin
                  if (!unmasked_ok && !masked) begin
                     closed = 1'b1;
                     push(KIND_ERROR, 8'h00, 1'b0, CAUSE_NO_MASK);
                  end else begin
                     key     = '0;
                     key_idx = '0;
                     len_acc = '0;
                     if (b[6:0] == LEN_EXT16) begin
                        len_left = 2;
                        phase    = PH_EXTLEN;
                     end else if (b[6:0] == LEN_EXT64) begin
                        len_left = 8;
                        phase    = PH_EXTLEN;
                     end else begin
                        len_acc = {57'd0, b[6:0]};
                        length_done();
                     end
                  end
               end
            end
            PH_EXTLEN: begin
               if (len_acc > (cap >> 8)) len_acc = cap;
               else len_acc = {len_acc[55:0], b} & cap;
               len_left--;
               if (len_left == 0) length_done();
            end
            PH_MASK: begin
               key = {key[23:0], b};
               len_left--;
               if (len_left == 0) start_payload();
            end
            PH_PAYLOAD: begin
               plain = b ^ 8'(key >> (24 - 8 * key_idx));
               key_idx++;
               pay_left--;
               last = (pay_left == 0) && flags[4];
               if (pay_left == 0) phase = PH_HEAD1;
               push(KIND_PAYLOAD, plain, last, 1'b0);
               if (last) finish_message();
            end
            default: phase = PH_HEAD1;
         endcase
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      function void check_result(ws_result_type got);
         ws_result_type want;
         if (awaited.size() == 0) begin
            errors++;
            $display("%0t: result mismatch: expected none, actual kind %0h byte %0h",
                     $time, got.kind, got.data);
            return;
         end
         want = awaited.pop_front();
         compare_field("result_kind", 8'(want.kind), 8'(got.kind));
         compare_field("payload_byte", want.data, got.data);
         compare_field("message_opcode", 8'(want.opcode), 8'(got.opcode));
         compare_field("message_end", 8'(want.msg_end), 8'(got.msg_end));
         compare_field("error_cause", 8'(want.cause), 8'(got.cause));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_stream_byte;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [1:0]             rsp_result_kind;
   logic [7:0]             rsp_payload_byte;
   logic [3:0]             rsp_message_opcode;
   logic                   rsp_message_end;
   logic                   rsp_error_cause;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_wdata;

   frame_scoreboard_type sb;
   int                   send_pct;
   int                   rcv_pct;
   int                   sent_bytes;
   int                   hold_left;
   bit                   hold_request;
   int                   cycles;

   websocket_frame_receiver_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_stream_byte    (req_stream_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_message_opcode (rsp_message_opcode),
      .rsp_message_end    (rsp_message_end),
      .rsp_error_cause    (rsp_error_cause),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // sink: random stall, or a long hold-off on request
   initial begin
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result({rsp_result_kind, rsp_payload_byte, rsp_message_opcode,
                          rsp_message_end, rsp_error_cause});
      end
   end

   task send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b);
      sent_bytes++;
      @(negedge clock);
   endtask

   task send_header(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                    input logic msk, input logic [6:0] len7);
      send_byte({fin, rsv, op});
      send_byte({msk, len7});
   endtask

   task send_key(input logic [31:0] k);
      send_byte(k[31:24]);
      send_byte(k[23:16]);
      send_byte(k[15:8]);
      send_byte(k[7:0]);
   endtask

   task send_data_frame(input logic allow_unmasked, input int want_len);
      logic [63:0] room;
      logic [63:0] len;
      logic [3:0]  op;
      logic        msk;
      int          pick;
      room = {32'd0, sb.limit_bytes} - {31'd0, sb.msg_bytes} - 64'd1;
      pick = $urandom_range(9);
      if (want_len >= 0) len = 64'(want_len);
      else if (pick == 0) len = 64'd0;
      else if (pick == 1) len = 64'($urandom_range(126, 400));
      else len = 64'($urandom_range(1, 24));
      if (len > room) len = room;
      if (sb.msg_op == OP_CONT) begin
         if ($urandom_range(9) == 0) op = OP_CONT;
         else op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
      end else begin
         if ($urandom_range(7) == 0) op = $urandom_range(1) ? OP_TEXT : OP_BINARY;
         else op = OP_CONT;
      end
      msk  = allow_unmasked ? 1'($urandom) : 1'b1;
      pick = $urandom_range(9);
      if (pick == 0) begin
         send_header($urandom_range(99) < 55, 3'($urandom), op, msk, LEN_EXT64);
         for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end else if (len >= 126 || pick == 1) begin
         send_header($urandom_range(99) < 55, 3'($urandom), op, msk, LEN_EXT16);
         send_byte(len[15:8]);
         send_byte(len[7:0]);
      end else begin
         send_header($urandom_range(99) < 55, 3'($urandom), op, msk, len[6:0]);
      end
      if (msk) send_key($urandom);
      repeat (int'(len)) send_byte(8'($urandom));
   endtask

   task send_control();
      logic [3:0] op;
      op = $urandom_range(1) ? OP_PING : 4'($urandom_range(3, 15));
      send_byte({1'($urandom), 3'($urandom), op});
      send_byte(8'($urandom));
   endtask

   task run_frames(input int count, input logic allow_unmasked);
      int stop;
      stop = sent_bytes + count;
      while (sent_bytes < stop) begin
         if ($urandom_range(9) < 2) send_control();
         else send_data_frame(allow_unmasked, -1);
      end
   endtask

   task end_message();
      if (sb.msg_bytes != 0 || sb.msg_op != OP_CONT) begin
         send_header(1'b1, 3'b000, OP_CONT, 1'b1, 7'd0);
         send_key($urandom);
      end
   endtask

   // drop valid, wait for every result beat, then let the pipeline drain
   task settle();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task send_fatal_frame();
      if ($urandom_range(1)) begin
         send_header(1'b1, 3'b000, OP_TEXT, 1'b0, 7'($urandom_range(0, 125)));
      end else begin
         send_header(1'b1, 3'b000, OP_BINARY, 1'b1, LEN_EXT64);
         send_byte(8'($urandom_range(1, 255)));
         repeat (7) send_byte(8'($urandom));
      end
      // closed: these must be dropped
      repeat (6) send_byte(8'($urandom));
   endtask

   initial begin
      sb              = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_stream_byte = 8'h00;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      hold_request    = 1'b0;
      sent_bytes      = 0;
      send_pct        = 38;
      rcv_pct         = 49;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_header(1'b1, 3'b000, OP_PING, 1'b1, 7'd0);
      send_header(1'b1, 3'b000, OP_PONG, 1'b0, 7'd0);
      send_header(1'b0, 3'b111, OP_RESERVED, 1'b1, 7'h7F);
      send_header(1'b0, 3'b000, OP_TEXT, 1'b1, 7'd1);
      send_key(32'hFF00_0000);
      send_byte(8'h00);
      send_header(1'b1, 3'b000, OP_PING, 1'b1, 7'd0);
      send_header(1'b1, 3'b000, OP_CONT, 1'b1, LEN_EXT16);
      send_byte(8'h00);
      send_byte(8'h02);
      send_key(32'hA55A_0FF0);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_header(1'b1, 3'b000, OP_TEXT, 1'b1, 7'd0);
      send_key(32'h0000_0000);

      run_frames(220, 1'b0);
      end_message();
      settle();

      send_pct = 49;
      rcv_pct  = 38;
      write_reg(REG_ACCEPT_UNMASKED, 32'd1);
      write_reg(REG_MAX_MESSAGE, 32'd1);
      run_frames(60, 1'b1);
      settle();
      write_reg(REG_MAX_MESSAGE, 32'hFFFF_FFFF);
      run_frames(180, 1'b1);
      settle();

      send_pct = 0;
      rcv_pct  = 0;
      write_reg(REG_ACCEPT_UNMASKED, 32'd0);
      write_reg(REG_MAX_MESSAGE, sb.msg_bytes[31:0] + 32'($urandom_range(400, 3000)));
      hold_request = 1'b1;
      send_data_frame(1'b0, 60);
      run_frames(180, 1'b0);
      send_fatal_frame();
      settle();

      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
